>>> sv/vpm_pkg.sv
// Shared widths, codes, state type and control structs of the voxel point map.
`default_nettype none

package vpm_pkg;

    // Field widths
    localparam int COORD_W    = 32;
    localparam int VS_W       = 20;
    localparam int CAP_W      = 6;
    localparam int RANGE_W    = 24;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int TOTAL_W    = 14;
    localparam int REMOVED_W  = 9;
    localparam int RSLOT_W    = 8;
    localparam int RIDX_W     = 5;
    localparam int KEY_W      = 3 * COORD_W;

    // Stream and configuration port widths
    localparam int S_DATA_W   = 112;
    localparam int S_USER_W   = 3;
    localparam int M_DATA_W   = 120;
    localparam int M_USER_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Prune distance test: gaps at or above 2^GAP_W are always out of range
    localparam int GAP_W      = RANGE_W + 1;
    localparam int SQ_W       = 2 * GAP_W;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PRUNE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_STORED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_VOXEL_FULL = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SKIPPED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PRUNED     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_READ_OK    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_READ_EMPTY = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VOXEL_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POINTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE  = 2'd2;

    // Configuration reset values
    localparam logic [VS_W-1:0]    RST_VOXEL_SIZE = 20'd512;
    localparam logic [CAP_W-1:0]   RST_MAX_POINTS = 6'd20;
    localparam logic [RANGE_W-1:0] RST_MAX_RANGE  = 24'd102400;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SRCH_GO,
        S_SRCH_WAIT,
        S_INS_CNT,
        S_INS_WR,
        S_PRN_GO,
        S_PRN_WAIT,
        S_RD_CNT,
        S_RD_PT,
        S_RD_DONE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic div_start;
        logic walk_start;
        logic walk_prune;
        logic ins_cnt_rd;
        logic ins_wr;
        logic rd_cnt_rd;
        logic rd_pt_rd;
        logic rd_finish;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             finite;
        logic             div_done;
        logic             walk_done;
        logic             slot_found;
        logic             out_free;
    } t_stat;

endpackage

`default_nettype wire

>>> sv/vpm_div.sv
// Serial floor divider that forms the three voxel key coordinates one bit a cycle.
`default_nettype none

module vpm_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic signed [vpm_pkg::COORD_W-1:0] i_x,
    input  wire logic signed [vpm_pkg::COORD_W-1:0] i_y,
    input  wire logic signed [vpm_pkg::COORD_W-1:0] i_z,
    input  wire logic        [vpm_pkg::VS_W-1:0]    i_divisor,
    output logic signed      [vpm_pkg::COORD_W-1:0] o_kx,
    output logic signed      [vpm_pkg::COORD_W-1:0] o_ky,
    output logic signed      [vpm_pkg::COORD_W-1:0] o_kz,
    output logic                                    o_done
);
    import vpm_pkg::*;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic [5:0] LAST_STEP = 6'(COORD_W);

    logic                r_busy;
    logic                r_load;
    logic                r_done;
    logic [1:0]          r_axis;
    logic [5:0]          r_step;
    logic [COORD_W-1:0]  r_mag;
    logic                r_neg;
    logic [VS_W-1:0]     r_rem;
    logic [COORD_W-1:0]  r_quo;
    logic [COORD_W-1:0]  r_kx;
    logic [COORD_W-1:0]  r_ky;
    logic [COORD_W-1:0]  r_kz;

    logic [COORD_W-1:0]  w_sel;
    logic [VS_W:0]       w_rem_sh;
    logic [VS_W:0]       w_rem_nx;
    logic                w_ge;
    logic [COORD_W-1:0]  w_final;

    // Pick the axis being divided
    always_comb begin
        case (r_axis)
            AXIS_X:  w_sel = i_x;
            AXIS_Y:  w_sel = i_y;
            default: w_sel = i_z;
        endcase
    end

    // One restoring step and the floor correction for negative dividends
    assign w_rem_sh = {r_rem, r_mag[COORD_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, i_divisor};
    assign w_rem_nx = w_ge ? (w_rem_sh - {1'b0, i_divisor}) : w_rem_sh;
    assign w_final  = r_neg ? ((r_rem != '0) ? ~r_quo : (COORD_W'(0) - r_quo)) : r_quo;

    // Sequence the three axes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_load <= 1'b0;
            r_done <= 1'b0;
            r_axis <= AXIS_X;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_load <= 1'b1;
                r_axis <= AXIS_X;
            end else if (r_busy) begin
                if (r_load) begin
                    r_load <= 1'b0;
                    r_step <= '0;
                end else if (r_step == LAST_STEP) begin
                    if (r_axis == AXIS_Z) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                        r_load <= 1'b1;
                    end
                end else begin
                    r_step <= r_step + 6'd1;
                end
            end
        end
    end

    // Shift the quotient in and store each key
    always_ff @(posedge i_clk) begin
        if (r_busy && r_load) begin
            r_mag <= w_sel[COORD_W-1] ? (COORD_W'(0) - w_sel) : w_sel;
            r_neg <= w_sel[COORD_W-1];
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy && r_step != LAST_STEP) begin
            r_mag <= {r_mag[COORD_W-2:0], 1'b0};
            r_quo <= {r_quo[COORD_W-2:0], w_ge};
            r_rem <= w_rem_nx[VS_W-1:0];
        end else if (r_busy) begin
            case (r_axis)
                AXIS_X:  r_kx <= w_final;
                AXIS_Y:  r_ky <= w_final;
                default: r_kz <= w_final;
            endcase
        end
    end

    assign o_kx   = r_kx;
    assign o_ky   = r_ky;
    assign o_kz   = r_kz;
    assign o_done = r_done;

endmodule

`default_nettype wire

>>> sv/vpm_datapath.sv
// Slot tables, point store, slot walk pipeline, configuration and result register.
`default_nettype none

module vpm_datapath #(
    parameter int NUM_SLOTS       = 256,
    parameter int POINTS_PER_SLOT = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire vpm_pkg::t_cmd                     i_cmd,
    output vpm_pkg::t_stat                         o_stat,
    input  wire logic [vpm_pkg::S_DATA_W-1:0]      i_s_tdata,
    input  wire logic [vpm_pkg::S_USER_W-1:0]      i_s_tuser,
    input  wire logic                              i_cfg_valid,
    input  wire logic [vpm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [vpm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [vpm_pkg::M_DATA_W-1:0]           o_m_tdata,
    output logic [vpm_pkg::M_USER_W-1:0]           o_m_tuser
);
    import vpm_pkg::*;

    localparam int SLOT_W   = $clog2(NUM_SLOTS);
    localparam int WALK_W   = $clog2(NUM_SLOTS + 1);
    localparam int CNT_W    = $clog2(POINTS_PER_SLOT + 1);
    localparam int PT_DEPTH = NUM_SLOTS * POINTS_PER_SLOT;
    localparam int PT_AW    = $clog2(PT_DEPTH);
    localparam int PROD_W   = COORD_W + 1 + VS_W + 1;
    localparam int DIFF_W   = PROD_W + 2;

    // |c - 2*o| split into its low bits and a flag for anything above them
    function automatic logic [GAP_W:0] gap_split(input logic [PROD_W-1:0] c,
                                                 input logic [COORD_W-1:0] o);
        logic [DIFF_W-1:0] d;
        logic [DIFF_W-1:0] a;
        d = {{2{c[PROD_W-1]}}, c} - {{(DIFF_W-COORD_W-1){o[COORD_W-1]}}, o, 1'b0};
        a = d[DIFF_W-1] ? (DIFF_W'(0) - d) : d;
        return {(|a[DIFF_W-1:GAP_W]), a[GAP_W-1:0]};
    endfunction

    // Configuration
    logic [VS_W-1:0]     r_vs;
    logic [CAP_W-1:0]    r_max_pts;
    logic [RANGE_W-1:0]  r_max_range;
    logic [SQ_W-1:0]     r_lim;
    logic [VS_W-1:0]     w_vs;
    logic [GAP_W-1:0]    w_range2;

    // Request
    logic [REQ_W-1:0]    r_req;
    logic                r_finite;
    logic [COORD_W-1:0]  r_px;
    logic [COORD_W-1:0]  r_py;
    logic [COORD_W-1:0]  r_pz;
    logic [RSLOT_W-1:0]  r_rslot;
    logic [RIDX_W-1:0]   r_ridx;

    // Keys from the divider
    logic [COORD_W-1:0]  w_kx;
    logic [COORD_W-1:0]  w_ky;
    logic [COORD_W-1:0]  w_kz;
    logic                w_div_done;

    // Stores
    logic [KEY_W-1:0]    r_key_mem [NUM_SLOTS];
    logic [CNT_W-1:0]    r_cnt_mem [NUM_SLOTS];
    logic [KEY_W-1:0]    r_pt_mem  [PT_DEPTH];
    logic                r_slot_valid [NUM_SLOTS];
    logic [KEY_W-1:0]    r_key_q;
    logic [CNT_W-1:0]    r_cnt_q;
    logic [KEY_W-1:0]    r_pt_q;

    // Slot walk
    logic                r_walk_on;
    logic                r_walk_prune;
    logic [WALK_W-1:0]   r_walk_cnt;
    logic [SLOT_W-1:0]   w_walk_addr;
    logic                w_issue;
    logic                w_walk_done;
    logic                r_tg1, r_tg2, r_tg3, r_tg4;
    logic [SLOT_W-1:0]   r_s1_idx, r_s2_idx, r_s3_idx, r_s4_idx;
    logic                r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic [CNT_W-1:0]    r_s2_cnt, r_s3_cnt, r_s4_cnt;
    logic [PROD_W-1:0]   r_s2_cx, r_s2_cy, r_s2_cz;
    logic [GAP_W-1:0]    r_s3_lx, r_s3_ly, r_s3_lz;
    logic                r_s3_big;
    logic [SQ_W-1:0]     r_s4_sx, r_s4_sy, r_s4_sz;
    logic                r_s4_big;
    logic [GAP_W:0]      w_gx, w_gy, w_gz;
    logic [SQ_W+1:0]     w_sum;
    logic                w_prune_hit;
    logic                w_srch;
    logic                w_match;

    // Search result
    logic                r_hit_found;
    logic [SLOT_W-1:0]   r_hit_slot;
    logic                r_free_found;
    logic [SLOT_W-1:0]   r_free_slot;
    logic [SLOT_W-1:0]   w_tgt;
    logic                w_alloc;

    // Insert
    logic [CNT_W-1:0]    w_base;
    logic [CNT_W-1:0]    w_cap;
    logic                w_store;
    logic [31:0]         w_ins_lin;
    logic [PT_AW-1:0]    w_ins_addr;

    // Read
    logic [31:0]         w_rslot_ext;
    logic                w_rslot_in;
    logic [SLOT_W-1:0]   w_rslot_idx;
    logic [31:0]         w_rd_lin;
    logic [PT_AW-1:0]    w_rd_addr;
    logic [SLOT_W-1:0]   w_cnt_addr;
    logic                r_rd_valid_q;
    logic                r_rd_ok;

    // Result and output register
    logic [STATUS_W-1:0]  r_status;
    logic [COORD_W-1:0]   r_res_x;
    logic [COORD_W-1:0]   r_res_y;
    logic [COORD_W-1:0]   r_res_z;
    logic [REMOVED_W-1:0] r_removed;
    logic [TOTAL_W-1:0]   r_held;
    logic                 r_m_valid;
    logic [M_DATA_W-1:0]  r_m_data;
    logic [M_USER_W-1:0]  r_m_user;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs        <= RST_VOXEL_SIZE;
            r_max_pts   <= RST_MAX_POINTS;
            r_max_range <= RST_MAX_RANGE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VOXEL_SIZE: r_vs        <= i_cfg_data[VS_W-1:0];
                CFG_MAX_POINTS: r_max_pts   <= i_cfg_data[CAP_W-1:0];
                CFG_MAX_RANGE:  r_max_range <= i_cfg_data[RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    // Squared prune radius at twice scale
    assign w_vs     = (r_vs == '0) ? VS_W'(1) : r_vs;
    assign w_range2 = {r_max_range, 1'b0};
    always_ff @(posedge i_clk) begin
        r_lim <= w_range2 * w_range2;
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px     <= i_s_tdata[31:0];
            r_py     <= i_s_tdata[63:32];
            r_pz     <= i_s_tdata[95:64];
            r_rslot  <= i_s_tdata[103:96];
            r_ridx   <= i_s_tdata[108:104];
            r_req    <= i_s_tuser[1:0];
            r_finite <= i_s_tuser[2];
        end
    end

    vpm_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_x       (r_px),
        .i_y       (r_py),
        .i_z       (r_pz),
        .i_divisor (w_vs),
        .o_kx      (w_kx),
        .o_ky      (w_ky),
        .o_kz      (w_kz),
        .o_done    (w_div_done)
    );

    // Walk control
    assign w_walk_addr = r_walk_cnt[SLOT_W-1:0];
    assign w_issue     = r_walk_on && (r_walk_cnt < WALK_W'(NUM_SLOTS));
    assign w_walk_done = r_walk_on && !w_issue && !r_tg1 && !r_tg2 && !r_tg3 && !r_tg4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk_on <= 1'b0;
            r_tg1     <= 1'b0;
            r_tg2     <= 1'b0;
            r_tg3     <= 1'b0;
            r_tg4     <= 1'b0;
        end else begin
            if (i_cmd.walk_start) begin
                r_walk_on <= 1'b1;
            end else if (w_walk_done) begin
                r_walk_on <= 1'b0;
            end
            r_tg1 <= w_issue;
            r_tg2 <= r_tg1;
            r_tg3 <= r_tg2;
            r_tg4 <= r_tg3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_walk_cnt   <= '0;
            r_walk_prune <= i_cmd.walk_prune;
        end else if (w_issue) begin
            r_walk_cnt <= r_walk_cnt + WALK_W'(1);
        end
    end

    // Walk pipeline: key and count read, center product, gap, square, compare
    assign w_gx = gap_split(r_s2_cx, r_px);
    assign w_gy = gap_split(r_s2_cy, r_py);
    assign w_gz = gap_split(r_s2_cz, r_pz);

    always_ff @(posedge i_clk) begin
        r_s1_idx   <= w_walk_addr;
        r_s1_valid <= r_slot_valid[w_walk_addr];

        r_s2_idx   <= r_s1_idx;
        r_s2_valid <= r_s1_valid;
        r_s2_cnt   <= r_cnt_q;
        r_s2_cx    <= $signed({r_key_q[31:0], 1'b1}) * $signed({1'b0, w_vs});
        r_s2_cy    <= $signed({r_key_q[63:32], 1'b1}) * $signed({1'b0, w_vs});
        r_s2_cz    <= $signed({r_key_q[95:64], 1'b1}) * $signed({1'b0, w_vs});

        r_s3_idx   <= r_s2_idx;
        r_s3_valid <= r_s2_valid;
        r_s3_cnt   <= r_s2_cnt;
        r_s3_lx    <= w_gx[GAP_W-1:0];
        r_s3_ly    <= w_gy[GAP_W-1:0];
        r_s3_lz    <= w_gz[GAP_W-1:0];
        r_s3_big   <= w_gx[GAP_W] | w_gy[GAP_W] | w_gz[GAP_W];

        r_s4_idx   <= r_s3_idx;
        r_s4_valid <= r_s3_valid;
        r_s4_cnt   <= r_s3_cnt;
        r_s4_sx    <= r_s3_lx * r_s3_lx;
        r_s4_sy    <= r_s3_ly * r_s3_ly;
        r_s4_sz    <= r_s3_lz * r_s3_lz;
        r_s4_big   <= r_s3_big;
    end

    assign w_sum = (SQ_W+2)'(r_s4_sx) + (SQ_W+2)'(r_s4_sy) + (SQ_W+2)'(r_s4_sz);
    assign w_prune_hit = r_tg4 && r_walk_prune && r_s4_valid &&
                         (r_s4_big || (w_sum > (SQ_W+2)'(r_lim)));

    // Search: first valid slot with the key, else first free slot
    assign w_srch  = r_tg1 && !r_walk_prune;
    assign w_match = (r_key_q == {w_kz, w_ky, w_kx});

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (w_srch) begin
            if (r_s1_valid && w_match && !r_hit_found) begin
                r_hit_found <= 1'b1;
                r_hit_slot  <= r_s1_idx;
            end
            if (!r_s1_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_slot  <= r_s1_idx;
            end
        end
    end

    assign w_tgt   = r_hit_found ? r_hit_slot : r_free_slot;
    assign w_alloc = !r_hit_found;

    // Insert address and cap
    assign w_base     = w_alloc ? '0 : r_cnt_q;
    assign w_cap      = (32'(r_max_pts) < POINTS_PER_SLOT) ? CNT_W'(r_max_pts)
                                                           : CNT_W'(POINTS_PER_SLOT);
    assign w_store    = w_base < w_cap;
    assign w_ins_lin  = 32'(w_tgt) * POINTS_PER_SLOT + 32'(w_base);
    assign w_ins_addr = w_ins_lin[PT_AW-1:0];

    // Read address
    assign w_rslot_ext = 32'(r_rslot);
    assign w_rslot_in  = w_rslot_ext < NUM_SLOTS;
    assign w_rslot_idx = w_rslot_ext[SLOT_W-1:0];
    assign w_rd_lin    = w_rslot_ext * POINTS_PER_SLOT + 32'(r_ridx);
    assign w_rd_addr   = w_rd_lin[PT_AW-1:0];

    assign w_cnt_addr = r_walk_on ? w_walk_addr : (i_cmd.ins_cnt_rd ? w_tgt : w_rslot_idx);

    // Key store
    always_ff @(posedge i_clk) begin
        r_key_q <= r_key_mem[w_walk_addr];
        if (i_cmd.ins_wr && w_alloc) begin
            r_key_mem[w_tgt] <= {w_kz, w_ky, w_kx};
        end
    end

    // Count store
    always_ff @(posedge i_clk) begin
        r_cnt_q <= r_cnt_mem[w_cnt_addr];
        if (i_cmd.ins_wr) begin
            r_cnt_mem[w_tgt] <= w_store ? (w_base + CNT_W'(1)) : w_base;
        end
    end

    // Point store
    always_ff @(posedge i_clk) begin
        r_pt_q <= r_pt_mem[w_rd_addr];
        if (i_cmd.ins_wr && w_store) begin
            r_pt_mem[w_ins_addr] <= {r_pz, r_py, r_px};
        end
    end

    // Slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_slot_valid[i] <= 1'b0;
            end
        end else begin
            if (w_prune_hit) begin
                r_slot_valid[r_s4_idx] <= 1'b0;
            end
            if (i_cmd.ins_wr && w_alloc) begin
                r_slot_valid[w_tgt] <= 1'b1;
            end
        end
    end

    // Running point total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (w_prune_hit) begin
            r_held <= r_held - TOTAL_W'(r_s4_cnt);
        end else if (i_cmd.ins_wr && w_store) begin
            r_held <= r_held + TOTAL_W'(1);
        end
    end

    // Read checks
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_cnt_rd) begin
            r_rd_valid_q <= w_rslot_in && r_slot_valid[w_rslot_idx];
        end
        if (i_cmd.rd_pt_rd) begin
            r_rd_ok <= r_rd_valid_q && (32'(r_ridx) < 32'(r_cnt_q));
        end
    end

    // Result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status  <= ST_SKIPPED;
            r_res_x   <= '0;
            r_res_y   <= '0;
            r_res_z   <= '0;
            r_removed <= '0;
        end else begin
            if (i_cmd.walk_start && i_cmd.walk_prune) begin
                r_status <= ST_PRUNED;
            end
            if (w_prune_hit) begin
                r_removed <= r_removed + REMOVED_W'(1);
            end
            if (i_cmd.ins_cnt_rd && !(r_hit_found || r_free_found)) begin
                r_status <= ST_TABLE_FULL;
            end
            if (i_cmd.ins_wr) begin
                r_status <= w_store ? ST_STORED : ST_VOXEL_FULL;
            end
            if (i_cmd.rd_finish) begin
                if (r_rd_ok) begin
                    r_status <= ST_READ_OK;
                    r_res_x  <= r_pt_q[31:0];
                    r_res_y  <= r_pt_q[63:32];
                    r_res_z  <= r_pt_q[95:64];
                end else begin
                    r_status <= ST_READ_EMPTY;
                end
            end
        end
    end

    // Output register: hold until transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_m_data <= {1'b0, r_removed, r_held, r_res_z, r_res_y, r_res_x};
            r_m_user <= r_status;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    assign o_stat.req        = r_req;
    assign o_stat.finite     = r_finite;
    assign o_stat.div_done   = w_div_done;
    assign o_stat.walk_done  = w_walk_done;
    assign o_stat.slot_found = r_hit_found || r_free_found;
    assign o_stat.out_free   = !r_m_valid || i_m_tready;

endmodule

`default_nettype wire

>>> sv/vpm_ctrl.sv
// Request sequencer of the voxel point map.
`default_nettype none

module vpm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    output vpm_pkg::t_cmd       o_cmd,
    input  wire vpm_pkg::t_stat i_stat
);
    import vpm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_stat.req)
                    REQ_INSERT: n_state = i_stat.finite ? S_DIV_GO : S_FINISH;
                    REQ_PRUNE:  n_state = S_PRN_GO;
                    REQ_READ:   n_state = S_RD_CNT;
                    default:    n_state = S_FINISH;
                endcase
            end
            S_DIV_GO:    n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (i_stat.div_done) n_state = S_SRCH_GO;
            end
            S_SRCH_GO:   n_state = S_SRCH_WAIT;
            S_SRCH_WAIT: begin
                if (i_stat.walk_done) n_state = S_INS_CNT;
            end
            S_INS_CNT:   n_state = i_stat.slot_found ? S_INS_WR : S_FINISH;
            S_INS_WR:    n_state = S_FINISH;
            S_PRN_GO:    n_state = S_PRN_WAIT;
            S_PRN_WAIT: begin
                if (i_stat.walk_done) n_state = S_FINISH;
            end
            S_RD_CNT:    n_state = S_RD_PT;
            S_RD_PT:     n_state = S_RD_DONE;
            S_RD_DONE:   n_state = S_FINISH;
            S_FINISH: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // Commands; hold the input closed while in reset
    always_comb begin
        o_cmd            = '0;
        o_s_tready       = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = i_rst_n;
                o_cmd.load = i_s_tvalid && i_rst_n;
            end
            S_DIV_GO:  o_cmd.div_start = 1'b1;
            S_SRCH_GO: o_cmd.walk_start = 1'b1;
            S_INS_CNT: o_cmd.ins_cnt_rd = 1'b1;
            S_INS_WR:  o_cmd.ins_wr = 1'b1;
            S_PRN_GO: begin
                o_cmd.walk_start = 1'b1;
                o_cmd.walk_prune = 1'b1;
            end
            S_RD_CNT:  o_cmd.rd_cnt_rd = 1'b1;
            S_RD_PT:   o_cmd.rd_pt_rd = 1'b1;
            S_RD_DONE: o_cmd.rd_finish = 1'b1;
            S_FINISH:  o_cmd.out_load = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

>>> sv/voxel_point_map.sv
// Top level of the voxel point map: sequencer plus datapath.
//
// Input stream (i_s_*): one request per transfer: insert a point, prune around
// an origin, or read a stored point. Config channel (i_cfg_*): register writes,
// ready whenever out of reset; the user must write them only while no request
// is in flight, as the block does not enforce it. Output stream (o_m_*): exactly
// one result per request, in request order. Requests run one at a time:
//   insert: the serial floor divider forms the key, then the slot walk runs
//           over the key memory, then the count read and the write.
//   prune:  the walk reads one slot a cycle into the distance pipeline.
//   read:   through the count and point memory reads.
// The result waits in an output register; a new request is taken while it
// waits, and the block stalls at the end of that request until the register
// is free. Synchronous reset clears every slot valid bit, the point total,
// the output valid and the configuration to its defaults; no clearing pass.
`default_nettype none

module voxel_point_map #(
    parameter int NUM_SLOTS       = 256,
    parameter int POINTS_PER_SLOT = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // coord_x, coord_y, coord_z, read_slot, read_index
    input  wire logic [vpm_pkg::S_DATA_W-1:0]   i_s_tdata,
    // req_type, coord_finite
    input  wire logic [vpm_pkg::S_USER_W-1:0]   i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // out_x, out_y, out_z, point_total, removed_slots
    output logic [vpm_pkg::M_DATA_W-1:0]        o_m_tdata,
    // status
    output logic [vpm_pkg::M_USER_W-1:0]        o_m_tuser,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [vpm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [vpm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import vpm_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_cfg_we;

    // Registers accept a write every cycle out of reset
    assign o_cfg_ready = i_rst_n;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    vpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    vpm_datapath #(
        .NUM_SLOTS       (NUM_SLOTS),
        .POINTS_PER_SLOT (POINTS_PER_SLOT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (w_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

`default_nettype wire

>>> sv/vpm_checker.sv
// Port-level checks of the voxel point map and their binding to the top level.
`default_nettype none

module vpm_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_s_tvalid,
    input wire logic                           o_s_tready,
    input wire logic                           o_m_tvalid,
    input wire logic                           i_m_tready,
    input wire logic [vpm_pkg::M_DATA_W-1:0]   o_m_tdata,
    input wire logic [vpm_pkg::M_USER_W-1:0]   o_m_tuser
);
    import vpm_pkg::*;

    // Coordinates are zero on every result but a successful read
    a_coords_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ST_READ_OK) |-> (o_m_tdata[95:0] == '0))
        else $error("coordinates set on a non-read result");

    // Only a prune reports freed voxels
    a_removed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ST_PRUNED) |-> (o_m_tdata[118:110] == '0))
        else $error("freed voxel count on a non-prune result");

    // A request transfer makes the block busy for the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted back to back");

    // A stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule

bind voxel_point_map vpm_checker u_vpm_checker (.*);

`default_nettype wire
